>>> design/crc32tfc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 trailer frame checker package
// Shared constants, the check status type and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package crc32tfc_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [3:0]  MIN_LENGTH   = 4'd10;
    localparam logic [3:0]  MAGIC_BYTES  = 4'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_BAD_MAGIC = 2'd2,
        ST_CRC_ERR   = 2'd3
    } t_check_status;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> design/crc32_trailer_frame_checker.sv
// ----------------------------------------------------------------------------
// CRC-32 trailer frame checker
// Checks length, magic word and CRC-32 trailer of a byte-serial frame.
// ----------------------------------------------------------------------------
// The block accepts one frame byte per cycle, save when a final byte is held
// back, and reports one status transaction for each frame. The status is
// registered as its final byte leaves the input register, which waits for a
// free output register. Each byte passes an input register and then a single
// byte-wise CRC-32 update (reflected, polynomial 0xEDB88320) with the length,
// magic and trailer comparisons, whose result lands in the output register;
// the CRC update sets the clock period. The output register lets a new frame
// stream in while a status still waits to be taken; only a final byte waits for
// it. Write the expected magic word only while no frame is in progress.
module crc32_trailer_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_frame_byte,
    input  logic        i_in_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_out_frame_ok,
    output logic [1:0]  o_out_check_status,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);
    import crc32tfc_pkg::*;

    logic [31:0]   r_expected_magic;
    logic          r_s1_valid;
    logic [7:0]    r_s1_byte;
    logic          r_s1_last;
    logic          r_out_valid;
    t_check_status r_out_status;

    t_check_status status;
    logic          out_free;
    logic          s1_advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_advance = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_ready = !r_s1_valid || s1_advance;

    crc32tfc_frame_state u_frame_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (s1_advance),
        .i_frame_byte     (r_s1_byte),
        .i_is_last        (r_s1_last),
        .i_expected_magic (r_expected_magic),
        .o_status         (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= '0;
        end else if (i_cfg_wr_en) begin
            r_expected_magic <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_byte <= i_in_frame_byte;
            r_s1_last <= i_in_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_out_status <= status;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_check_status = r_out_status;
    assign o_out_frame_ok     = (r_out_status == ST_OK);

endmodule

>>> design/crc32tfc_frame_state.sv
// ----------------------------------------------------------------------------
// CRC-32 trailer frame checker: frame state
// Holds the running CRC, trailer delay line, magic word and byte count, and
// works out the check status of the frame on its final byte.
// ----------------------------------------------------------------------------
module crc32tfc_frame_state (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [7:0]                  i_frame_byte,
    input  logic                        i_is_last,
    input  logic [31:0]                 i_expected_magic,
    output crc32tfc_pkg::t_check_status o_status
);
    import crc32tfc_pkg::*;

    logic [31:0] r_crc_accum;
    logic [31:0] r_trailer_delay;
    logic [31:0] r_magic_gather;
    logic [3:0]  r_byte_count;

    logic [31:0] n_crc_accum;
    logic [31:0] n_trailer_delay;
    logic [31:0] n_magic_gather;
    logic [3:0]  n_byte_count;

    always_comb begin
        if (r_byte_count >= MAGIC_BYTES) begin
            n_crc_accum = crc32_byte(r_crc_accum, r_trailer_delay[7:0]);
        end else begin
            n_crc_accum = r_crc_accum;
        end

        n_trailer_delay = {i_frame_byte, r_trailer_delay[31:8]};

        if (r_byte_count < MAGIC_BYTES) begin
            n_magic_gather = r_magic_gather
                           | ({24'd0, i_frame_byte} << {r_byte_count[1:0], 3'b000});
        end else begin
            n_magic_gather = r_magic_gather;
        end

        if (r_byte_count < MIN_LENGTH) begin
            n_byte_count = r_byte_count + 4'd1;
        end else begin
            n_byte_count = r_byte_count;
        end
    end

    always_comb begin
        if (n_byte_count < MIN_LENGTH) begin
            o_status = ST_TOO_SHORT;
        end else if (n_magic_gather != i_expected_magic) begin
            o_status = ST_BAD_MAGIC;
        end else if ((n_crc_accum ^ CRC_ALL_ONES) != n_trailer_delay) begin
            o_status = ST_CRC_ERR;
        end else begin
            o_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_accum     <= CRC_ALL_ONES;
            r_trailer_delay <= '0;
            r_magic_gather  <= '0;
            r_byte_count    <= '0;
        end else if (i_step) begin
            if (i_is_last) begin
                r_crc_accum     <= CRC_ALL_ONES;
                r_trailer_delay <= '0;
                r_magic_gather  <= '0;
                r_byte_count    <= '0;
            end else begin
                r_crc_accum     <= n_crc_accum;
                r_trailer_delay <= n_trailer_delay;
                r_magic_gather  <= n_magic_gather;
                r_byte_count    <= n_byte_count;
            end
        end
    end

endmodule

>>> design/crc32tfc_checker.sv
// ----------------------------------------------------------------------------
// CRC-32 trailer frame checker: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module crc32tfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_in_frame_byte,
    input logic        i_in_is_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_out_frame_ok,
    input logic [1:0]  o_out_check_status,
    input logic        i_cfg_wr_en
);
    import crc32tfc_pkg::*;

    // A stalled status transaction holds its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_check_status) && $stable(o_out_frame_ok))
        else $error("stalled status transaction changed");

    // A waiting byte transaction holds its valid and its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_in_frame_byte) && $stable(i_in_is_last))
        else $error("waiting byte transaction changed");

    // The pass flag agrees with the status code.
    a_ok_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_frame_ok == (o_out_check_status == ST_OK)))
        else $error("frame_ok disagrees with check_status");

    // The magic word is written only while no transaction is pending.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> !o_out_valid && !i_in_valid)
        else $error("magic word written while busy");

    // Reset leaves no status transaction pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("status valid after reset");

endmodule

bind crc32_trailer_frame_checker crc32tfc_checker u_crc32tfc_checker (.*);

>>> test/frame_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame status checker
// Watches the byte channel, the status channel and the magic word register of
// the CRC-32 trailer frame checker. It predicts the status of every frame and
// compares each status transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_status_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_frame_byte,
    input  logic        i_in_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_out_frame_ok,
    input  logic [1:0]  i_out_check_status,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output int          o_mismatches,
    output int          o_statuses_due
);
    import crc32tfc_pkg::*;

    typedef struct packed {
        logic          ok;
        t_check_status status;
    } t_frame_verdict;

    t_frame_verdict verdicts_due[$];
    logic [31:0]    magic_word;
    logic [31:0]    crc_run;
    logic [31:0]    tail_bytes;
    logic [31:0]    head_bytes;
    logic [3:0]     bytes_seen;

    function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc,
                                                   input logic [7:0]  data);
        logic [31:0] r;
        r = crc ^ {24'd0, data};
        repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: status mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic clear_frame();
        crc_run    = CRC_ALL_ONES;
        tail_bytes = '0;
        head_bytes = '0;
        bytes_seen = '0;
    endtask

    always @(posedge i_clk) begin
        t_frame_verdict want;
        t_check_status  status;
        if (!i_rst_n) begin
            verdicts_due.delete();
            magic_word   = '0;
            o_mismatches = 0;
            clear_frame();
        end else begin
            if (i_cfg_wr_en) begin
                magic_word = i_cfg_wr_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("transaction with status %0d and none due",
                                              i_out_check_status));
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_out_frame_ok !== want.ok) begin
                        report_mismatch($sformatf("frame_ok %b, expected %b",
                                                  i_out_frame_ok, want.ok));
                    end
                    if (i_out_check_status !== want.status) begin
                        report_mismatch($sformatf("check_status %0d, expected %s",
                                                  i_out_check_status, want.status.name()));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (bytes_seen >= MAGIC_BYTES) begin
                    crc_run = crc_shift_byte(crc_run, tail_bytes[7:0]);
                end
                tail_bytes = {i_in_frame_byte, tail_bytes[31:8]};
                if (bytes_seen < MAGIC_BYTES) begin
                    head_bytes[bytes_seen * 8 +: 8] = i_in_frame_byte;
                end
                if (bytes_seen < MIN_LENGTH) begin
                    bytes_seen++;
                end
                if (i_in_is_last) begin
                    // Length is judged first, then the magic word, then the trailer.
                    if (bytes_seen < MIN_LENGTH) begin
                        status = ST_TOO_SHORT;
                    end else if (head_bytes != magic_word) begin
                        status = ST_BAD_MAGIC;
                    end else if ((crc_run ^ CRC_ALL_ONES) != tail_bytes) begin
                        status = ST_CRC_ERR;
                    end else begin
                        status = ST_OK;
                    end
                    want.ok      = (status == ST_OK);
                    want.status  = status;
                    verdicts_due = {verdicts_due, want};
                    clear_frame();
                end
            end
        end
        o_statuses_due <= verdicts_due.size();
    end

endmodule

>>> test/tb_crc32_trailer_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-32 trailer frame checker
// Streams a few directed frames and then random frames, nearly half of them
// well formed and all with random content, under several magic word settings.
// The sender works in bursts and the receiver stalls in changing modes; a
// separate checker predicts and compares every status transaction.
// ----------------------------------------------------------------------------
module tb_crc32_trailer_frame_checker;
    import crc32tfc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_BYTES = 230;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_MAGIC,
        FR_BAD_BOTH,
        FR_SHORT,
        FR_NOISE
    } t_frame_kind;

    typedef enum int {
        RDY_OPEN,
        RDY_COIN,
        RDY_SPARSE,
        RDY_EVERY_THIRD
    } t_ready_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_frame_byte;
    logic        i_in_is_last;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_out_frame_ok;
    logic [1:0]  o_out_check_status;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    int          mismatches;
    int          statuses_due;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          ready_span  = 0;
    int          ready_phase = 0;
    int          bytes_sent  = 0;
    t_ready_mode ready_mode  = RDY_OPEN;
    logic [31:0] magic_now   = '0;

    crc32_trailer_frame_checker uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_frame_byte    (i_in_frame_byte),
        .i_in_is_last       (i_in_is_last),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_frame_ok     (o_out_frame_ok),
        .o_out_check_status (o_out_check_status),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    frame_status_checker chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_in_frame_byte    (i_in_frame_byte),
        .i_in_is_last       (i_in_is_last),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_out_frame_ok     (o_out_frame_ok),
        .i_out_check_status (o_out_check_status),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_mismatches       (mismatches),
        .o_statuses_due     (statuses_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_span = $urandom_range(8, 80);
        end
        ready_span--;
        ready_phase++;
        case (ready_mode)
            RDY_OPEN: begin
                i_out_ready <= 1'b1;
            end
            RDY_COIN: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            RDY_SPARSE: begin
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_out_ready <= (ready_phase % 3 == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_crc32_trailer_frame_checker: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] crc_of_bytes(input logic [7:0] data[$], input int n);
        logic [31:0] crc;
        crc = CRC_ALL_ONES;
        for (int i = 0; i < n; i++) begin
            crc ^= {24'd0, data[i]};
            for (int k = 0; k < 8; k++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc ^ CRC_ALL_ONES;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_in_frame_byte <= value;
        i_in_is_last    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame_kind kind, input int len);
        logic [7:0]  frame[$];
        logic [31:0] head;
        logic [31:0] tail;
        int          pick;
        head = magic_now;
        if (kind == FR_BAD_MAGIC || kind == FR_BAD_BOTH) begin
            head ^= 32'd1 << $urandom_range(0, 31);
        end
        for (int i = 0; i < len; i++) begin
            if (i < 4 && kind != FR_NOISE) begin
                frame = {frame, head[8 * i +: 8]};
            end else begin
                frame = {frame, 8'($urandom_range(0, 255))};
            end
        end
        if (len >= MIN_LENGTH && kind != FR_NOISE) begin
            tail = crc_of_bytes(frame, len - 4);
            for (int i = 0; i < 4; i++) begin
                frame[len - 4 + i] = tail[8 * i +: 8];
            end
            if (kind == FR_BAD_CRC || kind == FR_BAD_BOTH) begin
                pick = $urandom_range(4, len - 1);
                frame[pick] = frame[pick] ^ (8'd1 << $urandom_range(0, 7));
            end
        end
        foreach (frame[i]) begin
            send_byte(frame[i], i == len - 1);
        end
    endtask

    task automatic send_random_frame();
        int          pick;
        int          len;
        t_frame_kind kind;
        pick = $urandom_range(0, 99);
        kind = pick < 48 ? FR_GOOD :
               pick < 62 ? FR_BAD_CRC :
               pick < 72 ? FR_BAD_MAGIC :
               pick < 78 ? FR_BAD_BOTH :
               pick < 90 ? FR_SHORT : FR_NOISE;
        pick = $urandom_range(0, 99);
        if (kind == FR_SHORT) begin
            len = $urandom_range(1, 9);
        end else if (kind == FR_NOISE) begin
            len = $urandom_range(1, 30);
        end else if (pick < 70) begin
            len = $urandom_range(10, 20);
        end else if (pick < 95) begin
            len = $urandom_range(21, 40);
        end else begin
            len = $urandom_range(41, 64);
        end
        send_frame(kind, len);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (statuses_due == 0);
    endtask

    task automatic write_magic(input logic [31:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        magic_now = value;
    endtask

    initial begin
        logic [31:0] magic_settings[5];
        magic_settings = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom, 32'h8000_0001};
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_in_frame_byte <= 8'd0;
        i_in_is_last    <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= 32'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A lone final byte is both short and off-magic; the next frame has
        // both a bad magic word and a bad trailer; the last one saturates the
        // length count and must pass.
        send_byte(8'hFF, 1'b1);
        send_frame(FR_BAD_BOTH, 10);
        send_frame(FR_GOOD, 14);

        foreach (magic_settings[p]) begin
            write_magic(magic_settings[p]);
            while (bytes_sent < 25 + (p + 1) * PHASE_BYTES) begin
                send_random_frame();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && statuses_due == 0) begin
            $display("tb_crc32_trailer_frame_checker: PASS");
        end else begin
            $display("tb_crc32_trailer_frame_checker: FAIL");
        end
        $finish;
    end

endmodule
